// ===== rtl/ndrd_pkg.sv =====
// ndrd_pkg: shared types and constants for the ntfs data run decoder
// parse phases, list status codes, decoder state and result structs
// no dependencies
package ndrd_pkg;

    // widest length or offset field in bytes
    localparam logic [3:0] MaxFieldBytes = 4'd8;

    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_LENGTH = 2'd2,
        PH_OFFSET = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN      = 3'd0,
        ST_END      = 3'd1,
        ST_ZERO_LEN = 3'd2,
        ST_BOUNDS   = 3'd3,
        ST_WIDE     = 3'd4
    } t_status;

    // run list parse state
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  length_bytes;
        logic [3:0]  offset_bytes;
        logic [3:0]  byte_position;
        logic [63:0] length_accum;
        logic [63:0] offset_accum;
        logic [63:0] current_cluster;
    } t_state;

    // one decoded result
    typedef struct packed {
        logic [63:0] start_cluster;
        logic [63:0] cluster_count;
        t_status     status;
        logic        done;
    } t_result;

endpackage

// ===== rtl/ndrd_step.sv =====
// ndrd_step: combinational next-state and result logic for one run list byte
// byte insert, sign extension, 64-bit cluster add and bound compare
// depends on ndrd_pkg
module ndrd_step (
    input  ndrd_pkg::t_state  i_state,
    input  logic [7:0]        i_run_byte,
    input  logic              i_list_start,
    input  logic [63:0]       i_max_cluster,
    output ndrd_pkg::t_state  o_state,
    output logic              o_res_valid,
    output ndrd_pkg::t_result o_res
);
    import ndrd_pkg::*;

    t_state      work;
    logic [63:0] ins;
    logic [3:0]  pos_inc;
    logic        finish;
    logic [63:0] off_val;
    logic [6:0]  off_bits;
    logic [63:0] low_mask;
    logic [5:0]  sign_idx;
    logic [63:0] sum;

    always_comb begin
        // a list start restarts the cluster number and takes the byte as a header
        work = i_state;
        if (i_list_start) begin
            work.current_cluster = 64'd0;
            work.phase           = PH_HEADER;
        end

        o_state     = work;
        o_res_valid = 1'b0;
        o_res       = '{start_cluster: 64'd0, cluster_count: 64'd0,
                        status: ST_RUN, done: 1'b0};
        ins         = {56'd0, i_run_byte} << {work.byte_position[2:0], 3'b000};
        pos_inc     = work.byte_position + 4'd1;
        finish      = 1'b0;
        off_val     = work.offset_accum;

        // per-phase byte handling
        unique case (work.phase)
            PH_HEADER: begin
                if (i_run_byte == 8'd0) begin
                    o_res_valid   = 1'b1;
                    o_res.status  = ST_END;
                    o_res.done    = 1'b1;
                    o_state.phase = PH_DONE;
                end else begin
                    o_state.length_bytes = i_run_byte[3:0];
                    o_state.offset_bytes = i_run_byte[7:4];
                    if (i_run_byte[3:0] == 4'd0) begin
                        o_res_valid   = 1'b1;
                        o_res.status  = ST_ZERO_LEN;
                        o_res.done    = 1'b1;
                        o_state.phase = PH_DONE;
                    end else if (i_run_byte[3:0] > MaxFieldBytes ||
                                 i_run_byte[7:4] > MaxFieldBytes) begin
                        o_res_valid   = 1'b1;
                        o_res.status  = ST_WIDE;
                        o_res.done    = 1'b1;
                        o_state.phase = PH_DONE;
                    end else begin
                        o_state.byte_position = 4'd0;
                        o_state.length_accum  = 64'd0;
                        o_state.offset_accum  = 64'd0;
                        o_state.phase         = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH: begin
                o_state.length_accum  = work.length_accum | ins;
                o_state.byte_position = pos_inc;
                if (pos_inc >= work.length_bytes) begin
                    if (work.offset_bytes == 4'd0) begin
                        finish = 1'b1;
                    end else begin
                        o_state.byte_position = 4'd0;
                        o_state.phase         = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                off_val               = work.offset_accum | ins;
                o_state.offset_accum  = off_val;
                o_state.byte_position = pos_inc;
                if (pos_inc >= work.offset_bytes) begin
                    finish = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // sign-extend the offset field and move the running cluster number
        off_bits = {work.offset_bytes, 3'b000};
        low_mask = (64'd1 << off_bits) - 64'd1;
        sign_idx = 6'(off_bits - 7'd1);
        if (work.offset_bytes != 4'd0 && work.offset_bytes < 4'd8 &&
            off_val[sign_idx]) begin
            off_val = off_val | ~low_mask;
        end
        sum = work.current_cluster + off_val;

        // run complete: report it, and end the list when out of bounds
        if (finish) begin
            o_state.current_cluster = sum;
            o_res_valid             = 1'b1;
            o_res.start_cluster     = sum;
            o_res.cluster_count     = o_state.length_accum;
            if (sum > i_max_cluster) begin
                o_res.status  = ST_BOUNDS;
                o_res.done    = 1'b1;
                o_state.phase = PH_DONE;
            end else begin
                o_res.status  = ST_RUN;
                o_res.done    = 1'b0;
                o_state.phase = PH_HEADER;
            end
        end
    end

endmodule

// ===== rtl/ntfs_data_run_decoder.sv =====
// ntfs_data_run_decoder: one run list byte per transfer, one result per decoded run and one at each list end
// path: the byte that ends a run passes the input register, then loads the result register when that is free
// throughput: one byte per cycle; a waiting result holds the byte behind it and stalls input
// reset: synchronous active low; parser waits for a list start, max_cluster is zero
// depends on ndrd_pkg and ndrd_step
module ntfs_data_run_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_run_byte,
    input  logic        i_list_start,
    // configuration
    input  logic        i_max_cluster_we,
    input  logic [63:0] i_max_cluster,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_run_start_cluster,
    output logic [63:0] o_run_cluster_count,
    output logic [2:0]  o_list_status,
    output logic        o_list_done
);
    import ndrd_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_run_byte;
    logic        r_list_start;
    logic [63:0] r_max_cluster;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_result     r_res;
    t_result     n_res;
    logic        res_valid;
    logic        out_free;
    logic        advance;

    // handshake: the result register frees when empty or being taken
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    ndrd_step u_step (
        .i_state      (r_state),
        .i_run_byte   (r_run_byte),
        .i_list_start (r_list_start),
        .i_max_cluster(r_max_cluster),
        .o_state      (n_state),
        .o_res_valid  (res_valid),
        .o_res        (n_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_run_byte   <= i_run_byte;
            r_list_start <= i_list_start;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cluster <= 64'd0;
        end else if (i_max_cluster_we) begin
            r_max_cluster <= i_max_cluster;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_DONE, length_bytes: 4'd0, offset_bytes: 4'd0,
                         byte_position: 4'd0, length_accum: 64'd0,
                         offset_accum: 64'd0, current_cluster: 64'd0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res_valid;
        end
        if (advance && res_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_run_start_cluster = r_res.start_cluster;
    assign o_run_cluster_count = r_res.cluster_count;
    assign o_list_status       = r_res.status;
    assign o_list_done         = r_res.done;

endmodule
